[hdl/utf8_script_class_scorer_macros.svh]
// ---------------------------------------------------------------------------
// utf8_script_class_scorer assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef UTF8_SCRIPT_CLASS_SCORER_MACROS_SVH
`define UTF8_SCRIPT_CLASS_SCORER_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define USCS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define USCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define USCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/uscs_pkg.sv]
// ---------------------------------------------------------------------------
// uscs_pkg
// Shared constants, types and decode helpers of the UTF-8 script scorer.
// ---------------------------------------------------------------------------
package uscs_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int BYTE_W      = 8;
  localparam int SCORE_W     = 18;
  localparam int TOTAL_W     = 16;
  localparam int CP_W        = 21;
  localparam int LEN_W       = 3;
  localparam int POS_W       = 3;
  localparam int PEND_DEPTH  = 3;
  localparam int WIN_DEPTH   = 4;
  // Wide enough for the unsaturated score and for the saturation compares.
  localparam int CALC_W = (COUNT_WIDTH + 4 > SCORE_W + 1) ? COUNT_WIDTH + 4 : SCORE_W + 1;

  localparam logic [CP_W-1:0]    CYR_LO     = 21'h000400;
  localparam logic [CP_W-1:0]    CYR_HI     = 21'h00052F;
  localparam logic [CP_W-1:0]    DIGIT_LO   = 21'h000030;
  localparam logic [CP_W-1:0]    DIGIT_HI   = 21'h000039;
  localparam logic [CP_W-1:0]    UPPER_LO   = 21'h000041;
  localparam logic [CP_W-1:0]    UPPER_HI   = 21'h00005A;
  localparam logic [CP_W-1:0]    LOWER_LO   = 21'h000061;
  localparam logic [CP_W-1:0]    LOWER_HI   = 21'h00007A;
  localparam logic [BYTE_W-1:0]  LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0]  LEAD2_CODE = 8'hC0;
  localparam logic [BYTE_W-1:0]  LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0]  LEAD3_CODE = 8'hE0;
  localparam logic [BYTE_W-1:0]  LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0]  LEAD4_CODE = 8'hF0;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 18'h3FFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 16'hFFFF;
  localparam int                 CYR_BONUS  = 60;
  localparam int                 CYR_MIN    = 5;
  localparam int                 LAT_MIN    = 5;

  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAIL,
    ST_SCORE
  } uscs_state_t;

  typedef struct packed {
    logic step;        // non-final byte accepted
    logic tail_load;   // final byte accepted, load the closing run
    logic tail_step;   // scan one position of the closing run
    logic score_load;  // compute result, load output, clear counters
  } uscs_cmd_t;

  typedef struct packed {
    logic tail_done;
    logic out_free;
  } uscs_sts_t;

  function automatic logic [LEN_W-1:0] seq_len_of(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    if (b[BYTE_W-1] == 1'b0) len = LEN_ONE;
    else if ((b & LEAD2_MASK) == LEAD2_CODE) len = LEN_TWO;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) len = LEN_THREE;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) len = LEN_FOUR;
    else len = LEN_NONE;
    return len;
  endfunction

  // Continuation bytes contribute their low six bits whatever their top bits.
  function automatic logic [CP_W-1:0] decode_seq(input logic [BYTE_W-1:0] b0,
                                                 input logic [BYTE_W-1:0] b1,
                                                 input logic [BYTE_W-1:0] b2,
                                                 input logic [BYTE_W-1:0] b3,
                                                 input logic [LEN_W-1:0]  len);
    logic [CP_W-1:0] cp;
    unique case (len)
      LEN_ONE:   cp = {13'd0, b0};
      LEN_TWO:   cp = {10'd0, b0[4:0], b1[5:0]};
      LEN_THREE: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      LEN_FOUR:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default:   cp = '0;
    endcase
    return cp;
  endfunction

  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

[hdl/uscs_if.sv]
// ---------------------------------------------------------------------------
// uscs_if
// Valid/ready channels of the UTF-8 script scorer: byte input and result.
// ---------------------------------------------------------------------------
interface uscs_in_if
  import uscs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface uscs_out_if
  import uscs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] text_score;
  logic [TOTAL_W-1:0] letter_total;
  logic [TOTAL_W-1:0] digit_total;
  logic [TOTAL_W-1:0] cyrillic_total;
  logic [TOTAL_W-1:0] latin_total;

  modport source(output valid, output text_score, output letter_total, output digit_total,
                 output cyrillic_total, output latin_total, input ready);
  modport sink(input valid, input text_score, input letter_total, input digit_total,
               input cyrillic_total, input latin_total, output ready);
endinterface

[hdl/uscs_ctrl.sv]
// ---------------------------------------------------------------------------
// uscs_ctrl
// Sequencer: takes bytes, runs the closing rescan and the score load.
// ---------------------------------------------------------------------------
module uscs_ctrl
  import uscs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  input  uscs_sts_t sts,
  output logic      in_ready,
  output uscs_cmd_t cmd
);

  uscs_state_t state_r;
  uscs_state_t state_nxt;
  logic        accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_last) state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        if (sts.tail_done) state_nxt = ST_SCORE;
      end
      ST_SCORE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    cmd.step       = accept && !in_last;
    cmd.tail_load  = accept && in_last;
    cmd.tail_step  = (state_r == ST_TAIL) && !sts.tail_done;
    cmd.score_load = (state_r == ST_SCORE) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/uscs_dp.sv]
// ---------------------------------------------------------------------------
// uscs_dp
// Datapath: sequence buffer, decoder, classifier, counters and result register.
// ---------------------------------------------------------------------------
module uscs_dp
  import uscs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  uscs_cmd_t          cmd,
  input  logic [BYTE_W-1:0]  in_data,
  output uscs_sts_t          sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SCORE_W-1:0] out_text_score,
  output logic [TOTAL_W-1:0] out_letter_total,
  output logic [TOTAL_W-1:0] out_digit_total,
  output logic [TOTAL_W-1:0] out_cyrillic_total,
  output logic [TOTAL_W-1:0] out_latin_total
);

  logic [BYTE_W-1:0]  pend_r [PEND_DEPTH];
  logic [BYTE_W-1:0]  pend_nxt [PEND_DEPTH];
  logic [1:0]         pcnt_r, pcnt_nxt;
  logic [LEN_W-1:0]   slen_r, slen_nxt;
  logic [BYTE_W-1:0]  tbuf_r [WIN_DEPTH];
  logic [BYTE_W-1:0]  tbuf_nxt [WIN_DEPTH];
  logic [POS_W-1:0]   tn_r, tn_nxt;
  logic [POS_W-1:0]   ti_r, ti_nxt;
  count_t             let_r, let_nxt;
  count_t             dig_r, dig_nxt;
  count_t             cyr_r, cyr_nxt;
  count_t             lat_r, lat_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [SCORE_W-1:0] oscore_r;
  logic [TOTAL_W-1:0] olet_r, odig_r, ocyr_r, olat_r;

  logic [BYTE_W-1:0]  cur [WIN_DEPTH];
  logic [BYTE_W-1:0]  win [WIN_DEPTH];
  logic [POS_W-1:0]   widx [WIN_DEPTH];
  logic [LEN_W-1:0]   in_len, t_len;
  logic               seq_done, t_fits;
  logic [CP_W-1:0]    cp;
  logic               cp_valid;
  logic               is_digit, is_latin, is_cyr;
  logic [CALC_W-1:0]  let_w, dig_w, cyr_w, lat_w, score_sum;
  logic [SCORE_W-1:0] score_sat;

  // Open sequence followed by the incoming byte, lead first.
  always_comb begin
    cur[0] = (pcnt_r > 2'd0) ? pend_r[0] : in_data;
    cur[1] = (pcnt_r > 2'd1) ? pend_r[1] : in_data;
    cur[2] = (pcnt_r > 2'd2) ? pend_r[2] : in_data;
    cur[3] = in_data;
  end

  // Window of the closing run that starts at the scan position.
  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      widx[k] = ti_r + POS_W'(k);
      win[k]  = tbuf_r[widx[k][1:0]];
    end
  end

  assign in_len   = seq_len_of(in_data);
  assign seq_done = ({1'b0, pcnt_r} + 3'd1) >= slen_r;
  assign t_len    = seq_len_of(win[0]);
  assign t_fits   = (t_len != LEN_NONE) &&
                    (({1'b0, ti_r} + {1'b0, t_len}) <= {1'b0, tn_r});

  // At most one decoded code point per cycle, from the byte stream or the rescan.
  always_comb begin
    cp       = '0;
    cp_valid = 1'b0;
    if (cmd.tail_step) begin
      cp       = decode_seq(win[0], win[1], win[2], win[3], t_len);
      cp_valid = t_fits;
    end else if (cmd.step) begin
      if (slen_r == LEN_NONE) begin
        cp       = decode_seq(in_data, in_data, in_data, in_data, LEN_ONE);
        cp_valid = (in_len == LEN_ONE);
      end else begin
        cp       = decode_seq(cur[0], cur[1], cur[2], cur[3], slen_r);
        cp_valid = seq_done;
      end
    end
  end

  assign is_digit = (cp >= DIGIT_LO) && (cp <= DIGIT_HI);
  assign is_latin = ((cp >= UPPER_LO) && (cp <= UPPER_HI)) ||
                    ((cp >= LOWER_LO) && (cp <= LOWER_HI));
  assign is_cyr   = (cp >= CYR_LO) && (cp <= CYR_HI);

  always_comb begin
    let_nxt = let_r;
    dig_nxt = dig_r;
    cyr_nxt = cyr_r;
    lat_nxt = lat_r;
    if (cmd.score_load) begin
      let_nxt = '0;
      dig_nxt = '0;
      cyr_nxt = '0;
      lat_nxt = '0;
    end else if (cp_valid) begin
      if (is_digit) dig_nxt = sat_inc(dig_r);
      if (is_latin || is_cyr) let_nxt = sat_inc(let_r);
      if (is_latin) lat_nxt = sat_inc(lat_r);
      if (is_cyr) cyr_nxt = sat_inc(cyr_r);
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    slen_nxt = slen_r;
    tbuf_nxt = tbuf_r;
    tn_nxt   = tn_r;
    ti_nxt   = ti_r;
    if (cmd.step) begin
      if (slen_r == LEN_NONE) begin
        if (in_len >= LEN_TWO) begin
          pend_nxt[0] = in_data;
          pcnt_nxt    = 2'd1;
          slen_nxt    = in_len;
        end
      end else if (seq_done) begin
        pcnt_nxt = 2'd0;
        slen_nxt = LEN_NONE;
      end else begin
        if (pcnt_r != 2'd3) pend_nxt[pcnt_r] = in_data;
        pcnt_nxt = pcnt_r + 2'd1;
      end
    end else if (cmd.tail_load) begin
      tbuf_nxt = cur;
      tn_nxt   = {1'b0, pcnt_r} + 3'd1;
      ti_nxt   = '0;
      pcnt_nxt = 2'd0;
      slen_nxt = LEN_NONE;
    end else if (cmd.tail_step) begin
      // A lead whose sequence runs past the end of the run is dropped.
      ti_nxt = t_fits ? ti_r + t_len : ti_r + 3'd1;
    end
  end

  always_comb begin
    let_w = CALC_W'(let_r);
    dig_w = CALC_W'(dig_r);
    cyr_w = CALC_W'(cyr_r);
    lat_w = CALC_W'(lat_r);
    score_sum = let_w + (dig_w >> 1);
    if (cyr_w >= CALC_W'(CYR_MIN)) score_sum = score_sum + (cyr_w << 1) + CALC_W'(CYR_BONUS);
    if (lat_w >= CALC_W'(LAT_MIN)) score_sum = score_sum + (lat_w >> 2);
    score_sat = (score_sum > CALC_W'(SCORE_MAX)) ? SCORE_MAX : score_sum[SCORE_W-1:0];
  end

  assign ovalid_nxt = cmd.score_load ? 1'b1 : (out_ready ? 1'b0 : ovalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r   <= 2'd0;
      slen_r   <= LEN_NONE;
      tn_r     <= '0;
      ti_r     <= '0;
      let_r    <= '0;
      dig_r    <= '0;
      cyr_r    <= '0;
      lat_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      pcnt_r   <= pcnt_nxt;
      slen_r   <= slen_nxt;
      tn_r     <= tn_nxt;
      ti_r     <= ti_nxt;
      let_r    <= let_nxt;
      dig_r    <= dig_nxt;
      cyr_r    <= cyr_nxt;
      lat_r    <= lat_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    tbuf_r <= tbuf_nxt;
    if (cmd.score_load) begin
      oscore_r <= score_sat;
      olet_r <= (let_w > CALC_W'(TOTAL_MAX)) ? TOTAL_MAX : let_w[TOTAL_W-1:0];
      odig_r <= (dig_w > CALC_W'(TOTAL_MAX)) ? TOTAL_MAX : dig_w[TOTAL_W-1:0];
      ocyr_r <= (cyr_w > CALC_W'(TOTAL_MAX)) ? TOTAL_MAX : cyr_w[TOTAL_W-1:0];
      olat_r <= (lat_w > CALC_W'(TOTAL_MAX)) ? TOTAL_MAX : lat_w[TOTAL_W-1:0];
    end
  end

  assign sts.tail_done     = (ti_r >= tn_r);
  assign sts.out_free      = !ovalid_r || out_ready;
  assign out_valid          = ovalid_r;
  assign out_text_score     = oscore_r;
  assign out_letter_total   = olet_r;
  assign out_digit_total    = odig_r;
  assign out_cyrillic_total = ocyr_r;
  assign out_latin_total    = olat_r;

endmodule

[hdl/utf8_script_class_scorer.sv]
// ---------------------------------------------------------------------------
// utf8_script_class_scorer
// Lenient UTF-8 decoder that counts digits, Latin and Cyrillic letters and
// emits the counts with a weighted script score at the end of each text.
// ---------------------------------------------------------------------------
// Channel   Dir  Payload                                            Request
// in_chan   in   data_byte[8], last_byte                            one byte
// out_chan  out  text_score[18], letter/digit/cyrillic/latin_total  one result
//
// A byte without last_byte is taken every cycle while in_chan.ready is high: decode and count in one step.
// A last byte is followed by a rescan of the closing run (one run position or one whole
// sequence per cycle), a state that sees the run finished and a score state, during
// all of which in_chan.ready is low.
// The score cycle waits while a previous result still sits in the output register.
// rst_n is synchronous: counters, sequence state and the output valid clear.
// ---------------------------------------------------------------------------
`include "utf8_script_class_scorer_macros.svh"

module utf8_script_class_scorer
  import uscs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  uscs_in_if.sink    in_chan,
  uscs_out_if.source out_chan
);

  uscs_cmd_t cmd;
  uscs_sts_t sts;
  logic      last_take;

  uscs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.last_byte),
    .sts      (sts),
    .in_ready (in_chan.ready),
    .cmd      (cmd)
  );

  uscs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_data            (in_chan.data_byte),
    .sts                (sts),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_text_score     (out_chan.text_score),
    .out_letter_total   (out_chan.letter_total),
    .out_digit_total    (out_chan.digit_total),
    .out_cyrillic_total (out_chan.cyrillic_total),
    .out_latin_total    (out_chan.latin_total)
  );

  assign last_take = in_chan.valid && in_chan.ready && in_chan.last_byte;

  `USCS_ASSERT_ALWAYS(a_cmd_onehot0, $onehot0(cmd), "more than one datapath command active")
  `USCS_ASSERT_NEXT(a_last_stalls_in, last_take, !in_chan.ready, "no stall after the final byte")
  `USCS_ASSERT_IMPL(a_out_src, $rose(out_chan.valid), $past(cmd.score_load), "result without score load")
  `USCS_ASSERT_NEXT(a_score_shows, cmd.score_load, out_chan.valid, "score load gave no result")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Byte-stream test of the UTF-8 script scorer. Directed and random texts are
// sent with random gaps while the result side stalls at random. A local
// decoder predicts each text summary, and the checker compares every field
// with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
  import uscs_pkg::*;

  localparam int          CLK_HALF     = 5;
  localparam int          MAX_IDLE     = 14;
  localparam int          RANDOM_BYTES = 600;
  localparam int          DRAIN_CYCLES = 12;
  localparam longint      CYCLE_LIMIT  = 1_500_000;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic [TOTAL_W-1:0] letters;
    logic [TOTAL_W-1:0] digits;
    logic [TOTAL_W-1:0] cyrillic;
    logic [TOTAL_W-1:0] latin;
  } text_summary_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  uscs_in_if  in_chan();
  uscs_out_if out_chan();

  utf8_script_class_scorer i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Decoder state of the predictor.
  logic [BYTE_W-1:0] held_bytes[PEND_DEPTH];
  int unsigned       held_cnt;
  int unsigned       open_len;
  count_t            n_letter;
  count_t            n_digit;
  count_t            n_cyr;
  count_t            n_latin;

  text_summary_t     expected_summaries[$];
  logic [BYTE_W-1:0] draft_text[$];
  int unsigned       mismatch_count = 0;
  longint unsigned   cycle_count = 0;
  bit                in_idle_on = 1'b1;
  bit                out_idle_on = 1'b1;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void clear_predictor();
    held_cnt = 0;
    open_len = 0;
    n_letter = '0;
    n_digit  = '0;
    n_cyr    = '0;
    n_latin  = '0;
  endfunction

  function automatic count_t count_up(input count_t c);
    return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic logic [TOTAL_W-1:0] clip_total(input count_t c);
    return (c > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(c);
  endfunction

  function automatic int unsigned lead_length(input logic [BYTE_W-1:0] b);
    if (!b[BYTE_W-1]) return 1;
    if ((b & LEAD2_MASK) == LEAD2_CODE) return 2;
    if ((b & LEAD3_MASK) == LEAD3_CODE) return 3;
    if ((b & LEAD4_MASK) == LEAD4_CODE) return 4;
    return 0;
  endfunction

  // Continuation bytes give their low six bits whatever their top bits are.
  function automatic logic [CP_W-1:0] code_point(input logic [BYTE_W-1:0] run[WIN_DEPTH],
                                                 input int unsigned at,
                                                 input int unsigned len);
    logic [CP_W-1:0] cp;
    case (len)
      1:       cp = run[at];
      2:       cp = run[at] & 8'h1F;
      3:       cp = run[at] & 8'h0F;
      default: cp = run[at] & 8'h07;
    endcase
    for (int unsigned k = 1; k < len; k++) cp = (cp << 6) | (run[at + k] & 8'h3F);
    return cp;
  endfunction

  function automatic void classify_cp(input logic [CP_W-1:0] cp);
    if (cp >= DIGIT_LO && cp <= DIGIT_HI) n_digit = count_up(n_digit);
    if ((cp >= UPPER_LO && cp <= UPPER_HI) || (cp >= LOWER_LO && cp <= LOWER_HI)) begin
      n_letter = count_up(n_letter);
      n_latin  = count_up(n_latin);
    end
    if (cp >= CYR_LO && cp <= CYR_HI) begin
      n_letter = count_up(n_letter);
      n_cyr    = count_up(n_cyr);
    end
  endfunction

  // Advances the predictor by one accepted byte; returns 1 when a summary is due.
  function automatic bit tally_byte(input logic [BYTE_W-1:0] b, input logic last,
                                    output text_summary_t s);
    logic [BYTE_W-1:0] run[WIN_DEPTH];
    int unsigned       n;
    int unsigned       i;
    int unsigned       len;
    longint unsigned   score;
    n = 0;
    s = '{default: '0};
    if (open_len != 0) begin
      for (int unsigned k = 0; k < held_cnt; k++) begin
        run[n] = held_bytes[k];
        n++;
      end
    end
    run[n] = b;
    n++;

    if (last) begin
      // A sequence that runs past the end loses its lead; the rest is read again.
      i = 0;
      while (i < n) begin
        len = lead_length(run[i]);
        if (len == 0 || i + len > n) begin
          i++;
        end else begin
          classify_cp(code_point(run, i, len));
          i += len;
        end
      end
      score = longint'(n_letter) + longint'(n_digit) / 2;
      if (n_cyr >= CYR_MIN) score += longint'(n_cyr) * 2 + CYR_BONUS;
      if (n_latin >= LAT_MIN) score += longint'(n_latin) / 4;
      s.score    = (score > SCORE_MAX) ? SCORE_MAX : SCORE_W'(score);
      s.letters  = clip_total(n_letter);
      s.digits   = clip_total(n_digit);
      s.cyrillic = clip_total(n_cyr);
      s.latin    = clip_total(n_latin);
      clear_predictor();
      return 1'b1;
    end

    if (open_len == 0) begin
      len = lead_length(b);
      if (len == 1) begin
        classify_cp(b);
      end else if (len >= 2) begin
        held_bytes[0] = b;
        held_cnt      = 1;
        open_len      = len;
      end
    end else if (n >= open_len) begin
      classify_cp(code_point(run, 0, open_len));
      held_cnt = 0;
      open_len = 0;
    end else begin
      held_bytes[held_cnt] = b;
      held_cnt++;
    end
    return 1'b0;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned   gap;
    text_summary_t s;
    gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last_byte <= last;
    do @(posedge clk); while (!in_chan.ready);
    if (tally_byte(b, last, s)) expected_summaries.insert(expected_summaries.size(), s);
  endtask

  task automatic send_text(input logic [BYTE_W-1:0] text[$]);
    foreach (text[i]) push_byte(text[i], i == text.size() - 1);
  endtask

  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    while (expected_summaries.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  initial begin : result_checker
    int unsigned   stall;
    text_summary_t want;
    stall = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (expected_summaries.size() == 0) begin
          $error("text_score: expected no request, actual %0d", out_chan.text_score);
          mismatch_count++;
        end else begin
          want = expected_summaries.pop_front();
          check_field("text_score", want.score, out_chan.text_score);
          check_field("letter_total", want.letters, out_chan.letter_total);
          check_field("digit_total", want.digits, out_chan.digit_total);
          check_field("cyrillic_total", want.cyrillic, out_chan.cyrillic_total);
          check_field("latin_total", want.latin, out_chan.latin_total);
        end
        stall = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        stall--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  function automatic void add_byte(input logic [BYTE_W-1:0] b);
    draft_text.insert(draft_text.size(), b);
  endfunction

  function automatic logic [BYTE_W-1:0] random_lead(input int unsigned len);
    logic [BYTE_W-1:0] r;
    r = BYTE_W'($urandom);
    case (len)
      2:       return LEAD2_CODE | (r & ~LEAD2_MASK);
      3:       return LEAD3_CODE | (r & ~LEAD3_MASK);
      default: return LEAD4_CODE | (r & ~LEAD4_MASK);
    endcase
  endfunction

  // A lead followed by too few continuation bytes.
  function automatic void add_partial();
    int unsigned len;
    len = $urandom_range(2, 4);
    add_byte(random_lead(len));
    repeat ($urandom_range(0, len - 2)) add_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
  endfunction

  function automatic void add_token();
    int unsigned     kind;
    int unsigned     len;
    logic [CP_W-1:0] cp;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      add_byte(BYTE_W'(DIGIT_LO + $urandom_range(0, 9)));
    end else if (kind < 50) begin
      if ($urandom_range(0, 1) == 0) add_byte(BYTE_W'(UPPER_LO + $urandom_range(0, 25)));
      else add_byte(BYTE_W'(LOWER_LO + $urandom_range(0, 25)));
    end else if (kind < 70) begin
      // Two-byte code points around the Cyrillic range, both edges included.
      cp = $urandom_range(CYR_LO - 16, CYR_HI + 16);
      add_byte(LEAD2_CODE | BYTE_W'(cp >> 6));
      add_byte(8'h80 | BYTE_W'(cp & 21'h3F));
    end else if (kind < 76) begin
      add_byte(BYTE_W'($urandom_range(0, 127)));
    end else if (kind < 84) begin
      // Continuation bytes sometimes lack the 10 prefix, which the block accepts.
      len = $urandom_range(2, 4);
      add_byte(random_lead(len));
      repeat (len - 1) begin
        if ($urandom_range(0, 3) == 0) add_byte(BYTE_W'($urandom));
        else add_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
      end
    end else if (kind < 90) begin
      add_byte(BYTE_W'($urandom));
    end else if (kind < 95) begin
      if ($urandom_range(0, 1) == 0) add_byte(BYTE_W'($urandom_range(8'h80, 8'hBF)));
      else add_byte(BYTE_W'($urandom_range(8'hF8, 8'hFF)));
    end else begin
      add_partial();
    end
  endfunction

  task automatic test_ascii_classes();
    send_text('{8'h2F, 8'h30, 8'h39, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h7B});
  endtask

  // Stray bytes, then code points just below, at and above the Cyrillic range.
  task automatic test_stray_and_cyrillic_bounds();
    send_text('{8'h80, 8'hFF, 8'hCF, 8'hBF, 8'hD0, 8'h80, 8'hD4, 8'hAF, 8'hD4, 8'hB0});
  endtask

  // Overlong forms and continuation bytes without the 10 prefix.
  task automatic test_lenient_continuation();
    send_text('{8'hC1, 8'h81, 8'hC0, 8'hF1, 8'hE0, 8'h80, 8'hB0});
  endtask

  task automatic test_unfinished_tail();
    send_text('{8'hF0, 8'hD0, 8'h80});
    send_text('{8'hE0, 8'h41});
    send_text('{8'hC3});
  endtask

  task automatic test_random_texts();
    int unsigned sent;
    bit          drained;
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_BYTES) begin
      draft_text.delete();
      repeat ($urandom_range(1, 16)) add_token();
      if ($urandom_range(0, 3) == 0) add_partial();
      if ($urandom_range(0, 3) == 0) in_idle_on = !in_idle_on;
      if ($urandom_range(0, 3) == 0) out_idle_on = !out_idle_on;
      send_text(draft_text);
      sent += draft_text.size();
      if (!drained && sent >= RANDOM_BYTES / 2) begin
        wait_for_results();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    in_chan.valid     = 1'b0;
    in_chan.data_byte = '0;
    in_chan.last_byte = 1'b0;
    clear_predictor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_ascii_classes();
    test_stray_and_cyrillic_bounds();
    test_lenient_continuation();
    test_unfinished_tail();
    test_random_texts();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
